// ----- src/tmef_pkg.sv -----
// ----------------------------------------------------------------------------
// tmef_pkg: shared constants and types of the trimmed mean EMA filter
// Field widths, register indexes, Q16 constants and the status record of
// the serial arithmetic units.
// ----------------------------------------------------------------------------
package tmef_pkg;

  // Parameter defaults
  localparam int ADC_BITS_DEF   = 12;
  localparam int MAX_WINDOW_DEF = 50;

  // Stream fields
  localparam int SAMPLE_W    = 12;
  localparam int S_TDATA_W   = 16;
  localparam int MEAN_W      = 12;
  localparam int MV_W        = 20;
  localparam int EMA_W       = 28;
  localparam int M_TDATA_W   = MEAN_W + MV_W + EMA_W + MV_W;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int CNT_CFG_W   = 6;
  localparam int ALPHA_W     = 17;
  localparam int MVQ_W       = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_CODE  = 2'd2;

  localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST = 6'd21;
  localparam logic [ALPHA_W-1:0]   EMA_ALPHA_RST    = 17'd13107;
  localparam logic [MVQ_W-1:0]     MV_PER_CODE_RST  = 24'd52812;

  // Q16 arithmetic
  localparam int FRAC_W = 16;
  localparam int MIN_WINDOW = 3;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN = 17'd655;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  // Shared serial multiplier
  localparam int MUL_A_W = EMA_W;
  localparam int MUL_B_W = MVQ_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- src/tmef_div.sv -----
// ----------------------------------------------------------------------------
// tmef_div: restoring serial divider
// Produces one quotient bit per cycle; done pulses with the quotient final.
// ----------------------------------------------------------------------------
module tmef_div
  import tmef_pkg::*;
#(
  parameter int NUM_W = 18,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output unit_sts_t        sts
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (cnt != '0) begin
      if (!diff[DEN_W+1]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign sts.busy = (cnt != '0);
  assign sts.done = done;

endmodule

// ----- src/tmef_mac.sv -----
// ----------------------------------------------------------------------------
// tmef_mac: serial dual multiply-accumulate
// Forms a1*b1 + a2*b2 taking one bit of each multiplier per cycle, MSB first.
// ----------------------------------------------------------------------------
module tmef_mac
  import tmef_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W,
  parameter int P_W = MUL_P_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a1,
  input  logic [A_W-1:0] a2,
  input  logic [B_W-1:0] b1,
  input  logic [B_W-1:0] b2,
  output logic [P_W-1:0] product,
  output unit_sts_t      sts
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0] a1r;
  logic [A_W-1:0] a2r;
  logic [B_W-1:0] b1sh;
  logic [B_W-1:0] b2sh;
  logic [P_W-1:0] acc;
  logic [P_W-1:0] pp;
  logic [CNT_W-1:0] cnt;
  logic             done;

  always_comb begin
    pp = (b1sh[B_W-1] ? P_W'(a1r) : '0) + (b2sh[B_W-1] ? P_W'(a2r) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a1r  <= a1;
      a2r  <= a2;
      b1sh <= b1;
      b2sh <= b2;
      acc  <= '0;
    end else if (cnt != '0) begin
      acc  <= {acc[P_W-2:0], 1'b0} + pp;
      b1sh <= {b1sh[B_W-2:0], 1'b0};
      b2sh <= {b2sh[B_W-2:0], 1'b0};
    end
  end

  assign product  = acc;
  assign sts.busy = (cnt != '0);
  assign sts.done = done;

endmodule

// ----- src/trimmed_mean_ema_adc_filter.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_ema_adc_filter: windowed trimmed mean with Q16 EMA
// Averages a window of ADC samples without its extremes, smooths the mean
// and scales both values to millivolts.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream, one transaction per cycle while a window
//   is open. Registers are written on the cfg_ channel (always ready), only
//   while the block is idle; the user must keep to this, as the block does not enforce it.
//   When the last sample of a window is taken, s_tready drops while a serial
//   divider forms the trimmed mean and one shared bit-serial multiplier runs
//   three passes: mean to millivolts, the EMA update, EMA to millivolts.
//   The result then moves to the output register once that register is free,
//   and s_tready rises again.
//   The result waits in the output register on m_; a stalled receiver does
//   not stop the next window from filling, but a second result is held back
//   until the first transaction completes.
//   Reset restores the register defaults, empties the window, clears the
//   EMA and its primed flag and empties the output register.
// ----------------------------------------------------------------------------
module trimmed_mean_ema_adc_filter
  import tmef_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, [15:12] zero
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] mean_code, [31:12] mean_mv,
                                           // [59:32] smoothed_q16, [79:60] smoothed_mv
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = CW + CNT_W;
  localparam int LEN_W = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MMV  = 3'd2;
  localparam logic [2:0] ST_EMA  = 3'd3;
  localparam logic [2:0] ST_SMV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;

  logic [CNT_CFG_W-1:0] sample_count;
  logic [ALPHA_W-1:0]   ema_alpha_q16;
  logic [MVQ_W-1:0]     mv_per_code_q16;

  logic [CNT_W-1:0] window_count;
  logic [SUM_W-1:0] window_sum;
  logic [CW-1:0]    window_min;
  logic [CW-1:0]    window_max;
  logic [EMA_W-1:0] ema_value;
  logic             ema_primed;

  logic [CW-1:0]    mean;
  logic [MV_W-1:0]  mean_mv;
  logic [MV_W-1:0]  smoothed_mv;

  logic [MEAN_W-1:0] out_mean;
  logic [MV_W-1:0]   out_mean_mv;
  logic [EMA_W-1:0]  out_ema;
  logic [MV_W-1:0]   out_smv;

  logic [CW-1:0]    s;
  logic [CW-1:0]    min_new;
  logic [CW-1:0]    max_new;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] count_new;
  logic [LEN_W-1:0] len_cfg;
  logic [LEN_W-1:0] len;
  logic             close;
  logic             accept;
  logic [SUM_W-1:0] dividend;
  logic [CNT_W-1:0] divisor;
  logic             div_start;
  logic [SUM_W-1:0] div_q;
  unit_sts_t        div_sts;

  logic [ALPHA_W-1:0] alpha_cl;
  logic [ALPHA_W-1:0] alpha_eff;
  logic [ALPHA_W-1:0] beta_eff;
  logic [MUL_A_W-1:0] mul_a1;
  logic [MUL_A_W-1:0] mul_a2;
  logic [MUL_B_W-1:0] mul_b1;
  logic [MUL_B_W-1:0] mul_b2;
  logic               mul_start;
  logic [MUL_P_W-1:0] mul_p;
  unit_sts_t          mul_sts;
  logic [EMA_W-1:0]   ema_new;
  logic               load;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    s         = s_tdata[CW-1:0];
    min_new   = (s < window_min) ? s : window_min;
    max_new   = (s > window_max) ? s : window_max;
    sum_new   = window_sum + SUM_W'(s);
    count_new = window_count + 1'b1;
    len_cfg   = LEN_W'(sample_count);
    if (len_cfg < LEN_W'(MIN_WINDOW)) begin
      len = LEN_W'(MIN_WINDOW);
    end else if (len_cfg > LEN_W'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = len_cfg;
    end
    close     = (LEN_W'(count_new) >= len);
    dividend  = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
    divisor   = count_new - CNT_W'(2);
    div_start = accept && close;
  end

  always_comb begin
    if (ema_alpha_q16 < ALPHA_MIN) begin
      alpha_cl = ALPHA_MIN;
    end else if (ema_alpha_q16 > ALPHA_ONE) begin
      alpha_cl = ALPHA_ONE;
    end else begin
      alpha_cl = ema_alpha_q16;
    end
    alpha_eff = ema_primed ? alpha_cl : ALPHA_ONE;
    beta_eff  = ALPHA_ONE - alpha_eff;
    ema_new   = mul_p[FRAC_W +: EMA_W];
  end

  always_comb begin
    mul_a1    = '0;
    mul_a2    = '0;
    mul_b1    = '0;
    mul_b2    = '0;
    mul_start = 1'b0;
    case (state)
      ST_DIV: begin
        mul_a1    = MUL_A_W'(div_q[CW-1:0]);
        mul_b1    = mv_per_code_q16;
        mul_start = div_sts.done;
      end
      ST_MMV: begin
        mul_a1    = MUL_A_W'({mean, {FRAC_W{1'b0}}});
        mul_a2    = ema_value;
        mul_b1    = MUL_B_W'(alpha_eff);
        mul_b2    = MUL_B_W'(beta_eff);
        mul_start = mul_sts.done;
      end
      ST_EMA: begin
        mul_a1    = ema_new;
        mul_b1    = mv_per_code_q16;
        mul_start = mul_sts.done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  tmef_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (div_q),
    .sts      (div_sts)
  );

  tmef_mac #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W),
    .P_W (MUL_P_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a1      (mul_a1),
    .a2      (mul_a2),
    .b1      (mul_b1),
    .b2      (mul_b2),
    .product (mul_p),
    .sts     (mul_sts)
  );

  assign load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= SAMPLE_COUNT_RST;
      ema_alpha_q16   <= EMA_ALPHA_RST;
      mv_per_code_q16 <= MV_PER_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: sample_count    <= cfg_data[CNT_CFG_W-1:0];
        REG_EMA_ALPHA:    ema_alpha_q16   <= cfg_data[ALPHA_W-1:0];
        REG_MV_PER_CODE:  mv_per_code_q16 <= cfg_data[MVQ_W-1:0];
        default:          sample_count    <= sample_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_count <= '0;
      window_sum   <= '0;
      window_min   <= '1;
      window_max   <= '0;
      ema_value    <= '0;
      ema_primed   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        if (close) begin
          window_count <= '0;
          window_sum   <= '0;
          window_min   <= '1;
          window_max   <= '0;
        end else begin
          window_count <= count_new;
          window_sum   <= sum_new;
          window_min   <= min_new;
          window_max   <= max_new;
        end
      end
      case (state)
        ST_IDLE: if (div_start) state <= ST_DIV;
        ST_DIV:  if (div_sts.done) state <= ST_MMV;
        ST_MMV:  if (mul_sts.done) state <= ST_EMA;
        ST_EMA: begin
          if (mul_sts.done) begin
            ema_value  <= ema_new;
            ema_primed <= 1'b1;
            state      <= ST_SMV;
          end
        end
        ST_SMV:  if (mul_sts.done) state <= ST_DONE;
        ST_DONE: if (load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_sts.done) begin
      mean <= div_q[CW-1:0];
    end
    if (state == ST_MMV && mul_sts.done) begin
      mean_mv <= mul_p[FRAC_W +: MV_W];
    end
    if (state == ST_SMV && mul_sts.done) begin
      smoothed_mv <= mul_p[2*FRAC_W +: MV_W];
    end
    if (load) begin
      out_mean    <= MEAN_W'(mean);
      out_mean_mv <= mean_mv;
      out_ema     <= ema_value;
      out_smv     <= smoothed_mv;
    end
  end

  assign m_tdata = {out_smv, out_ema, out_mean_mv, out_mean};

  a_close_starts_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ST_DIV)
    else $error("window close did not start the division");

  a_window_empty: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (window_count == '0 && window_sum == '0))
    else $error("window filled while a result was being computed");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (!div_sts.busy && !mul_sts.busy))
    else $error("arithmetic unit busy while idle");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("result overwrote a pending transaction");

  a_primed_by_ema: assert property (@(posedge clk) disable iff (rst)
    $rose(ema_primed) |-> $past(state) == ST_EMA)
    else $error("EMA primed outside its update");

endmodule

// ----- tb/trimmed_mean_ema_adc_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_ema_adc_filter_tb: self-checking bench of the trimmed mean filter
// Streams ADC samples in bursts under several register settings, predicts
// each window result (trimmed mean, Q16 EMA, millivolt scaling with
// saturation) and checks every result transaction field by field, while the
// receiver stalls at random and once holds off long enough to back up the
// sample input.
// ----------------------------------------------------------------------------
module trimmed_mean_ema_adc_filter_tb;
  import tmef_pkg::*;

  localparam int          RANDOM_ITEMS  = 900;
  localparam int          SETTLE_CYCLES = 160;
  localparam int          PRESSURE_HOLD = 600;
  localparam logic [63:0] CODE_MASK     = 64'((1 << ADC_BITS_DEF) - 1);
  localparam logic [63:0] EMA_MASK      = (64'd1 << EMA_W) - 1;
  localparam logic [63:0] MV_MAX        = (64'd1 << MV_W) - 1;

  typedef struct packed {
    logic [MV_W-1:0]   smoothed_mv;
    logic [EMA_W-1:0]  smoothed_q16;
    logic [MV_W-1:0]   mean_mv;
    logic [MEAN_W-1:0] mean_code;
  } filt_result_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_HOLD} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // filter model state and registers
  logic [CNT_CFG_W-1:0] count_reg = SAMPLE_COUNT_RST;
  logic [ALPHA_W-1:0]   alpha_reg = EMA_ALPHA_RST;
  logic [MVQ_W-1:0]     mv_reg    = MV_PER_CODE_RST;
  int                   win_cnt   = 0;
  logic [63:0]          win_sum   = '0;
  logic [SAMPLE_W-1:0]  win_min   = '1;
  logic [SAMPLE_W-1:0]  win_max   = '0;
  logic [63:0]          ema_q16   = '0;
  bit                   ema_primed = 1'b0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  filt_result_t        expected_results[$];
  int                  samples_queued = 0;
  int                  samples_taken  = 0;
  int                  results_checked = 0;
  int                  reg_writes = 0;
  int                  fail_count = 0;
  int                  stall_run = 0;
  int                  longest_stall = 0;
  bit                  s_taken = 1'b0;

  int       burst_left = 0;
  int       gap_left   = 0;
  int       rx_left    = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  bit       pressure_done = 1'b0;

  trimmed_mean_ema_adc_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mv_clip(input logic [63:0] v);
    return (v > MV_MAX) ? MV_MAX : v;
  endfunction

  // fold one sample into the window; return 1 with the result when it closes
  function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] smp,
                                       output filt_result_t res);
    logic [63:0] span;
    logic [63:0] rate;
    logic [63:0] mean;
    span = 64'(count_reg);
    if (span < 64'(MIN_WINDOW)) span = 64'(MIN_WINDOW);
    if (span > 64'(MAX_WINDOW_DEF)) span = 64'(MAX_WINDOW_DEF);
    rate = 64'(alpha_reg);
    if (rate < 64'(ALPHA_MIN)) rate = 64'(ALPHA_MIN);
    if (rate > 64'(ALPHA_ONE)) rate = 64'(ALPHA_ONE);
    res = '0;
    if (smp < win_min) win_min = smp;
    if (smp > win_max) win_max = smp;
    win_sum += 64'(smp);
    win_cnt++;
    if (64'(win_cnt) < span) return 1'b0;
    mean = (win_sum - 64'(win_min) - 64'(win_max)) / 64'(win_cnt - 2);
    mean &= CODE_MASK;
    if (!ema_primed) begin
      ema_q16 = mean << FRAC_W;
      ema_primed = 1'b1;
    end else begin
      ema_q16 = (rate * (mean << FRAC_W) + (64'(ALPHA_ONE) - rate) * ema_q16) >> FRAC_W;
    end
    ema_q16 &= EMA_MASK;
    res.mean_code    = mean[MEAN_W-1:0];
    res.mean_mv      = MV_W'(mv_clip((mean * 64'(mv_reg)) >> FRAC_W));
    res.smoothed_q16 = ema_q16[EMA_W-1:0];
    res.smoothed_mv  = MV_W'(mv_clip((ema_q16 * 64'(mv_reg)) >> (2 * FRAC_W)));
    win_cnt = 0;
    win_sum = '0;
    win_min = '1;
    win_max = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // sample driver: bursts of random length with random gaps
  always @(negedge clk) begin
    logic                nv;
    logic [SAMPLE_W-1:0] nd;
    nv = s_tvalid;
    nd = s_tdata[SAMPLE_W-1:0];
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || s_taken) begin
      nv = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
        if (pending_samples.size() > 0) begin
          nd = pending_samples.pop_front();
          nv = 1'b1;
          burst_left--;
        end
      end else begin
        gap_left--;
      end
    end
    s_tvalid <= nv;
    s_tdata  <= S_TDATA_W'(nd);
  end

  // result receiver: open, random and held stretches, one long hold-off
  always @(negedge clk) begin
    int r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        if (!pressure_done && results_checked >= 8) begin
          rx_mode = RX_HOLD;
          rx_left = PRESSURE_HOLD;
          pressure_done = 1'b1;
        end else begin
          r = $urandom_range(0, 9);
          rx_mode = (r < 4) ? RX_OPEN : (r < 8) ? RX_RANDOM : RX_HOLD;
          rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 80);
        end
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
        default:   m_tready <= 1'b0;
      endcase
    end
  end

  // monitor: check results, then predict from accepted samples
  always @(posedge clk) begin
    filt_result_t got;
    filt_result_t want;
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (s_tvalid && !s_tready) stall_run++;
      else stall_run = 0;
      if (stall_run > longest_stall) longest_stall = stall_run;
      if (m_tvalid && m_tready) begin
        got = filt_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, expected nothing got %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("mean_code", 32'(want.mean_code), 32'(got.mean_code));
          check_field("mean_mv", 32'(want.mean_mv), 32'(got.mean_mv));
          check_field("smoothed_q16", 32'(want.smoothed_q16), 32'(got.smoothed_q16));
          check_field("smoothed_mv", 32'(want.smoothed_mv), 32'(got.smoothed_mv));
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        samples_taken++;
        if (absorb_sample(s_tdata[SAMPLE_W-1:0], want)) expected_results.push_back(want);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_COUNT: count_reg = val[CNT_CFG_W-1:0];
      REG_EMA_ALPHA:    alpha_reg = val[ALPHA_W-1:0];
      REG_MV_PER_CODE:  mv_reg    = val[MVQ_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // write all three registers; unused upper data bits carry noise
  task automatic configure(input logic [CNT_CFG_W-1:0] cnt, input logic [ALPHA_W-1:0] alpha,
                           input logic [MVQ_W-1:0] mv);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'({$urandom, cnt}));
    write_reg(REG_EMA_ALPHA, CFG_DATA_W'({$urandom, alpha}));
    write_reg(REG_MV_PER_CODE, mv);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer(input logic [SAMPLE_W-1:0] smp);
    pending_samples.push_back(smp);
    samples_queued++;
  endtask

  // wait for every sample to be taken and every result checked, then settle
  task automatic drain();
    do @(negedge clk); while (samples_taken != samples_queued || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input int level);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 4095);
      1: v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
      default: begin
        v = level + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
    endcase
    return SAMPLE_W'(v);
  endfunction

  initial begin
    logic [CNT_CFG_W-1:0] count_corner[7] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd50, 6'd51, 6'd63};
    logic [ALPHA_W-1:0]   alpha_corner[6] = '{17'd0, 17'd654, 17'd655, 17'd65536,
                                              17'd65537, 17'h1FFFF};
    logic [MVQ_W-1:0]     mv_corner[4]    = '{24'd0, 24'd1, 24'd52812, 24'hFFFFFF};
    logic [CNT_CFG_W-1:0] cnt;
    logic [ALPHA_W-1:0]   alpha;
    logic [MVQ_W-1:0]     mv;
    int                   total_random;
    int                   phase_items;
    int                   level;
    bit                   first_phase;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // shortest window, lowest alpha, full scale so millivolts reach their top
    configure(6'd0, 17'd0, 24'hFFFFFF);
    offer(12'd0); offer(12'hFFF); offer(12'hFFF);
    offer(12'hFFF); offer(12'd0); offer(12'd0);
    offer(12'h800); offer(12'h800); offer(12'h800);
    drain();

    // open a long window, then shrink it so the next sample closes it
    configure(6'd63, 17'h1FFFF, 24'd0);
    offer(12'h001); offer(12'h002); offer(12'h004); offer(12'h008);
    offer(12'hAAA); offer(12'h555); offer(12'hF0F);
    drain();
    configure(6'd3, 17'h1FFFF, 24'd0);
    offer(12'h3C3);
    drain();

    total_random = 0;
    first_phase  = 1'b1;
    while (total_random < RANDOM_ITEMS) begin
      if (first_phase) cnt = CNT_CFG_W'($urandom_range(3, 6));
      else if ($urandom_range(0, 3) == 0) cnt = count_corner[$urandom_range(0, 6)];
      else cnt = CNT_CFG_W'($urandom_range(3, 12));
      if ($urandom_range(0, 3) == 0) alpha = alpha_corner[$urandom_range(0, 5)];
      else alpha = ALPHA_W'($urandom_range(655, 65536));
      case ($urandom_range(0, 3))
        0: mv = mv_corner[$urandom_range(0, 3)];
        1: mv = MVQ_W'($urandom_range(0, 24'hFFFFFF));
        default: mv = MVQ_W'($urandom_range(1000, 400000));
      endcase
      configure(cnt, alpha, mv);
      level = $urandom_range(0, 4095);
      phase_items = $urandom_range(90, 130);
      repeat (phase_items) offer(draw_sample(level));
      total_random += phase_items;
      first_phase = 1'b0;
      drain();
    end

    $display("checked %0d window results from %0d samples over %0d register writes",
             results_checked, samples_taken, reg_writes);
    $display("longest run of back-pressure on the sample input: %0d cycles", longest_stall);
    if (fail_count == 0) begin
      $display("trimmed_mean_ema_adc_filter_tb: clean");
    end else begin
      $display("trimmed_mean_ema_adc_filter_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("trimmed_mean_ema_adc_filter_tb: errors");
    $finish;
  end

endmodule
